@@ rtl/fema_pkg.sv @@
// Shared types and constants for the element matrix apply block.
`default_nettype none
package fema_pkg;
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ELEM = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_STIFFNESS = 1'b0,
    REG_BOUNDARY  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_LANES,
    ST_UPD_RD,
    ST_UPD_WR
  } state_t;

  localparam int VAL_W    = 32;
  localparam int X2_W     = 34;
  localparam int NUM_W    = 40;
  localparam int PART_W   = 35;
  localparam int IDX_W    = 12;
  localparam int LVL_W    = 4;
  localparam int MAX_LEVEL = 15;
  localparam int DIV_BYTES = 5;
  // ceil(2^16 / 9): exact quotient for dividends below 2304
  localparam logic [12:0] RECIP9 = 13'd7282;
endpackage
`default_nettype wire

@@ rtl/fe_element_matrix_apply.sv @@
// Top level: node stores, element fetch, four row lanes and ordered scatter.
// Load: taken in one cycle, busy stays low. Read: result strobe one cycle after accept.
// Element: 5 fetch cycles (one input RAM port), 8 lane cycles, then 8 scatter slots of one
// cycle each, two for a slot that updates an output (up to 6), plus 1: busy 22 to 28.
// The receiver cannot stall; one item is in flight at a time.
// Reset (synchronous): control idle, stiffness_mode 0, boundary_mode 1; stores keep contents.
`default_nettype none
module fe_element_matrix_apply #(
  parameter int NODE_COUNT = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        cmd,
  input  wire logic [fema_pkg::IDX_W-1:0]        node_index,
  input  wire logic signed [fema_pkg::VAL_W-1:0] node_value,
  input  wire logic                              node_boundary,
  input  wire logic [fema_pkg::LVL_W-1:0]        level,
  input  wire logic [3:0]                        hang_code,
  input  wire logic [fema_pkg::IDX_W-1:0]        corner0_node,
  input  wire logic [fema_pkg::IDX_W-1:0]        corner1_node,
  input  wire logic [fema_pkg::IDX_W-1:0]        corner2_node,
  input  wire logic [fema_pkg::IDX_W-1:0]        corner3_node,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_addr,
  input  wire logic                              cfg_wdata,
  output logic                                   strobe,
  output logic [fema_pkg::IDX_W-1:0]             result_index,
  output logic signed [fema_pkg::VAL_W-1:0]      result_value
);
  import fema_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  state_t state, state_next;
  logic stiffness_mode, boundary_mode;
  logic [2:0] cnt, cnt_next;
  logic [3:0] slot, slot_next;
  logic [IDX_W-1:0] rd_index;
  logic [IDX_W-1:0] c0, c1, c2, c3;
  logic [LVL_W-1:0] lvl_q;
  logic [3:0] fc_q;
  logic signed [3:0][X2_W-1:0] x2, x2i;
  logic [3:0] bnd, ok, hang, lane_hang, lane_done_v;
  logic [1:0] par;
  logic signed [3:0][PART_W-1:0] parts;
  logic lane_go;
  logic accept;

  logic in_we;
  logic [AW-1:0] in_raddr;
  logic [VAL_W:0] in_rdata;
  logic acc_we;
  logic [AW-1:0] acc_waddr, acc_raddr;
  logic [VAL_W-1:0] acc_wdata, acc_rdata;

  logic [IDX_W-1:0] fetch_idx, tgt_idx;
  logic tgt_valid;
  logic [1:0] row, cap;
  logic signed [PART_W-1:0] tgt_part;
  logic signed [PART_W+1:0] sum;
  logic [VAL_W-1:0] sat;
  logic [LVL_W-1:0] lvl_clamped;

  function automatic logic node_ok(input logic [IDX_W-1:0] i);
    return 32'(i) < NODE_COUNT;
  endfunction

  function automatic logic [IDX_W-1:0] pick(input logic [1:0] s, input logic [IDX_W-1:0] a,
      input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] d);
    logic [IDX_W-1:0] v;
    unique case (s)
      2'd0:    v = a;
      2'd1:    v = b;
      2'd2:    v = c;
      default: v = d;
    endcase
    return v;
  endfunction

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  fema_ram #(.WIDTH(VAL_W + 1), .DEPTH(NODE_COUNT)) u_in_ram (
    .clk, .we(in_we), .waddr(AW'(node_index)), .wdata({node_boundary, node_value}),
    .raddr(in_raddr), .rdata(in_rdata)
  );

  fema_ram #(.WIDTH(VAL_W), .DEPTH(NODE_COUNT)) u_acc_ram (
    .clk, .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  // hanging decode: flag bit i marks corner c^3^(1<<i), parent c
  always_comb begin
    par  = fc_q[1:0];
    hang = '0;
    hang[par ^ 2'd2] = fc_q[2];
    hang[par ^ 2'd1] = fc_q[3];
    ok = {node_ok(c3), node_ok(c2), node_ok(c1), node_ok(c0)};
    for (int k = 0; k < 4; k++) begin
      x2i[k] = hang[k]
               ? X2_W'((35'(signed'(x2[k])) + 35'(signed'(x2[par]))) >>> 1) : x2[k];
    end
  end

  assign lvl_clamped = (32'(lvl_q) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL) : lvl_q;
  assign lane_hang   = hang;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    fema_lane #(.ROW(2'(g))) u_lane (
      .clk, .rst, .go(lane_go), .stiffness(stiffness_mode), .lvl(lvl_clamped),
      .hang(lane_hang[g]), .x2(x2i), .part(parts[g]), .done(lane_done_v[g])
    );
  end

  // scatter slot: row k = slot/2, second half of a row goes to the parent corner
  always_comb begin
    row       = slot[2:1];
    tgt_part  = parts[row];
    if (slot[0]) begin
      tgt_idx   = pick(par, c0, c1, c2, c3);
      tgt_valid = hang[row] && ok[par] && !bnd[par];
    end else begin
      tgt_idx   = pick(row, c0, c1, c2, c3);
      tgt_valid = ok[row] && !bnd[row];
    end
    sum = (PART_W+2)'(signed'(acc_rdata)) + (PART_W+2)'(tgt_part);
    if (sum > (PART_W+2)'(32'sh7fffffff)) begin
      sat = 32'h7fffffff;
    end else if (sum < -(PART_W+2)'(33'sh080000000)) begin
      sat = 32'h80000000;
    end else begin
      sat = sum[VAL_W-1:0];
    end
    fetch_idx = pick(cnt[1:0], c0, c1, c2, c3);
    cap       = 2'(cnt - 3'd1);
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    slot_next  = slot;
    in_we      = 1'b0;
    in_raddr   = AW'(fetch_idx);
    acc_we     = 1'b0;
    acc_waddr  = AW'(tgt_idx);
    acc_wdata  = sat;
    acc_raddr  = AW'(tgt_idx);
    lane_go    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        acc_raddr = AW'(node_index);
        if (accept) begin
          unique case (cmd_t'(cmd))
            CMD_LOAD: begin
              in_we     = node_ok(node_index);
              acc_we    = node_ok(node_index);
              acc_waddr = AW'(node_index);
              acc_wdata = (boundary_mode && node_boundary) ? node_value : '0;
            end
            CMD_ELEM: begin
              state_next = ST_FETCH;
              cnt_next   = '0;
            end
            CMD_READ: state_next = ST_READ;
            CMD_NONE: state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_FETCH: begin
        cnt_next = cnt + 3'd1;
        if (cnt == 3'd4) begin
          state_next = ST_LANES;
        end
      end
      ST_LANES: begin
        // last corner lands at the end of fetch; start the lanes on entry to ST_LANES
        lane_go   = (cnt == 3'd5);
        cnt_next  = '0;
        slot_next = '0;
        if (lane_done_v[0]) begin
          state_next = ST_UPD_RD;
        end
      end
      ST_UPD_RD: begin
        if (slot[3]) begin
          state_next = ST_IDLE;
        end else if (tgt_valid) begin
          state_next = ST_UPD_WR;
        end else begin
          slot_next = slot + 4'd1;
        end
      end
      ST_UPD_WR: begin
        acc_we     = 1'b1;
        slot_next  = slot + 4'd1;
        state_next = ST_UPD_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      stiffness_mode <= 1'b0;
      boundary_mode  <= 1'b1;
      cnt            <= '0;
      slot           <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      slot  <= slot_next;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_addr))
          REG_STIFFNESS: stiffness_mode <= cfg_wdata;
          REG_BOUNDARY:  boundary_mode  <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_index <= node_index;
      c0       <= corner0_node;
      c1       <= corner1_node;
      c2       <= corner2_node;
      c3       <= corner3_node;
      lvl_q    <= level;
      fc_q     <= hang_code;
    end
    if (state == ST_FETCH && cnt != 3'd0) begin
      bnd[cap] <= ok[cap] && boundary_mode && in_rdata[VAL_W];
      x2[cap]  <= (ok[cap] && !(boundary_mode && in_rdata[VAL_W]))
                  ? {in_rdata[VAL_W-1], in_rdata[VAL_W-1:0], 1'b0} : '0;
    end
  end

  assign strobe       = (state == ST_READ);
  assign result_index = rd_index;
  assign result_value = node_ok(rd_index) ? acc_rdata : '0;
endmodule
`default_nettype wire

@@ rtl/fema_ram.sv @@
// Generic single write, single read RAM with registered read data.
`default_nettype none
module fema_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/fema_lane.sv @@
// One matrix row: weighted sum of four corner values, then rounded scaling.
`default_nettype none
module fema_lane #(
  parameter logic [1:0] ROW = 2'd0
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   go,
  input  wire logic                                   stiffness,
  input  wire logic [fema_pkg::LVL_W-1:0]             lvl,
  input  wire logic                                   hang,
  input  wire logic signed [3:0][fema_pkg::X2_W-1:0]  x2,
  output logic signed [fema_pkg::PART_W-1:0]          part,
  output logic                                        done
);
  import fema_pkg::*;

  logic [2:0] phase;
  logic signed [NUM_W-1:0] num, num_next;
  logic neg;
  logic [NUM_W-1:0] tb;
  logic [NUM_W-1:0] t_next;
  logic [3:0] r;
  logic [NUM_W-1:0] q;
  logic [NUM_W-1:0] mag;
  logic [5:0] sh;
  logic [NUM_W:0] biased;
  logic [11:0] dx;
  logic [24:0] prod;
  logic [7:0] qd;

  function automatic logic signed [NUM_W-1:0] term(input logic signed [X2_W-1:0] x,
                                                  input logic [1:0] n, input logic stf);
    logic signed [NUM_W-1:0] xe;
    xe = NUM_W'(x);
    if (!stf) begin
      term = xe <<< (2 - n);
    end else begin
      unique case (n)
        2'd0:    term = (xe <<< 4) + (xe <<< 3);
        2'd1:    term = -((xe <<< 2) + (xe <<< 1));
        default: term = -((xe <<< 3) + (xe <<< 2));
      endcase
    end
  endfunction

  always_comb begin
    logic [1:0] d;
    num_next = '0;
    for (int j = 0; j < 4; j++) begin
      d = ROW ^ 2'(j);
      num_next = num_next + term(x2[j], 2'(d[0]) + 2'(d[1]), stiffness);
    end
  end

  // round half away: (|num| + den/2) >> s, then / 9 a byte per cycle
  always_comb begin
    mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    sh     = 6'd3 + 6'(hang) + (stiffness ? 6'd0 : {1'b0, lvl, 1'b0});
    biased = {1'b0, mag} + ((NUM_W+1)'(9) << (sh - 6'd1));
    t_next = NUM_W'(biased >> sh);
    dx     = {r, tb[NUM_W-1 -: 8]};
    prod   = 25'(dx) * 25'(RECIP9);
    qd     = prod[23:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (phase == 3'd0) begin
        if (go) begin
          phase <= 3'd1;
        end
      end else if (phase == 3'(DIV_BYTES + 1)) begin
        phase <= '0;
        done  <= 1'b1;
      end else begin
        phase <= phase + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phase == 3'd0) begin
      num <= num_next;
    end else if (phase == 3'd1) begin
      neg <= num[NUM_W-1];
      tb  <= t_next;
      r   <= '0;
      q   <= '0;
    end else begin
      r  <= 4'(dx - 12'(9 * 12'(qd)));
      q  <= {q[NUM_W-9:0], qd};
      tb <= tb << 8;
    end
  end

  assign part = neg ? -PART_W'(q) : PART_W'(q);
endmodule
`default_nettype wire

@@ rtl/fema_checker.sv @@
// Port-level checks for the element matrix apply block, bound to the top level.
`default_nettype none
module fema_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [1:0]                 cmd,
  input wire logic [fema_pkg::IDX_W-1:0] node_index,
  input wire logic                       strobe,
  input wire logic [fema_pkg::IDX_W-1:0] result_index
);
  import fema_pkg::*;

  // a result beat only answers a read taken the cycle before
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy && cmd == CMD_READ))
    else $error("result beat without a read");

  a_strobe_idx: assert property (@(posedge clk) disable iff (rst)
    strobe |-> result_index == $past(node_index))
    else $error("result index mismatch");

  a_read_strobe: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_READ) |=> strobe)
    else $error("read produced no result");

  a_elem_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_ELEM) |=> busy && !strobe)
    else $error("element did not occupy the block");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_LOAD) |=> !busy && !strobe)
    else $error("load held the block");
endmodule

bind fe_element_matrix_apply fema_checker u_fema_checker (.*);
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for fe_element_matrix_apply: queued driver, strobe monitor.
`timescale 1ns / 100ps
module testbench;
  import fema_pkg::*;

  typedef struct {
    logic        is_cfg;
    reg_idx_t    cfg_reg;
    logic        cfg_val;
    cmd_t        op;
    logic [11:0] node;
    logic [31:0] val;
    logic        bnd;
    logic [3:0]  lvl;
    logic [3:0]  fc;
    logic [11:0] corner [4];
  } beat_t;

  typedef struct {
    logic [11:0] idx;
    logic [31:0] val;
  } node_out_t;

  localparam int SETTLE  = 40;
  localparam int WD_LIMIT = 5000;
  localparam int POOL_N  = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] cmd = CMD_LOAD;
  logic [11:0] node_index = '0;
  logic signed [31:0] node_value = '0;
  logic node_boundary = 1'b0;
  logic [3:0] level = '0;
  logic [3:0] hang_code = '0;
  logic [11:0] corner0_node = '0, corner1_node = '0, corner2_node = '0, corner3_node = '0;
  logic cfg_we = 1'b0;
  logic cfg_addr = 1'b0;
  logic cfg_wdata = 1'b0;
  logic strobe;
  logic [11:0] result_index;
  logic signed [31:0] result_value;

  fe_element_matrix_apply u_dut (
    .clk, .rst, .start, .busy, .cmd, .node_index, .node_value, .node_boundary,
    .level, .hang_code, .corner0_node, .corner1_node, .corner2_node, .corner3_node,
    .cfg_we, .cfg_addr, .cfg_wdata, .strobe, .result_index, .result_value
  );

  always #1 clk = ~clk;

  // shadow of the node stores and registers
  logic signed [31:0] x_store [4096];
  bit                 flag_store [4096];
  logic signed [31:0] y_store [4096];
  bit stiff_m = 1'b0;
  bit bnd_m   = 1'b1;

  beat_t     pending_beats [$];
  node_out_t expected_reads [$];
  beat_t     cur;
  int        errs = 0;
  int        gap = 0;
  int        settle = 0;
  int        quiet = 0;
  bit        burst = 1'b0;
  logic [11:0] pool [POOL_N];

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint coef36(int r, int c);
    int d, n;
    d = r ^ c;
    n = (d & 1) + ((d >> 1) & 1);
    if (stiff_m) return (n == 0) ? 24 : ((n == 1) ? -6 : -12);
    return longint'(4 >> n);
  endfunction

  task automatic apply_element(beat_t b);
    longint x2 [4];
    int hc [4];
    bit interior [4];
    longint num, den, mag, part;
    int h;
    for (int k = 0; k < 4; k++) begin
      interior[k] = !(bnd_m && flag_store[b.corner[k]]);
      x2[k] = interior[k] ? 2 * longint'(x_store[b.corner[k]]) : 0;
      hc[k] = -1;
    end
    if (b.fc != 0) begin
      for (int k = 0; k < 2; k++) begin
        h = int'(b.fc[1:0]) ^ 3 ^ (1 << k);
        hc[h] = b.fc[2 + k] ? int'(b.fc[1:0]) : -1;
      end
    end
    for (int k = 0; k < 4; k++)
      if (hc[k] >= 0) x2[k] = (x2[k] + x2[hc[k]]) / 2;
    for (int k = 0; k < 4; k++) begin
      num = 0;
      for (int j = 0; j < 4; j++) num += coef36(k, j) * x2[j];
      den = 72;
      if (!stiff_m) den = den << (2 * int'(b.lvl));
      if (hc[k] >= 0) den = den << 1;
      mag = (num < 0) ? -num : num;
      part = (mag + den / 2) / den;
      if (num < 0) part = -part;
      if (interior[k])
        y_store[b.corner[k]] = sat32(longint'(y_store[b.corner[k]]) + part);
      if (hc[k] >= 0 && interior[hc[k]])
        y_store[b.corner[hc[k]]] = sat32(longint'(y_store[b.corner[hc[k]]]) + part);
    end
  endtask

  task automatic predict(beat_t b);
    node_out_t o;
    case (b.op)
      CMD_LOAD: begin
        x_store[b.node] = b.val;
        flag_store[b.node] = b.bnd;
        y_store[b.node] = (bnd_m && b.bnd) ? b.val : 32'sd0;
      end
      CMD_ELEM: apply_element(b);
      CMD_READ: begin
        o.idx = b.node;
        o.val = y_store[b.node];
        expected_reads.push_back(o);
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
    errs++;
  endtask

  // driver
  always @(posedge clk) begin
    logic nxt_start, nxt_we;
    beat_t b;
    nxt_start = start;
    nxt_we = 1'b0;
    if (!rst) begin
      settle = settle + 1;
      if (start && !busy) begin
        predict(cur);
        nxt_start = 1'b0;
        settle = 0;
      end
      if (!nxt_start) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_beats.size() > 0) begin
          b = pending_beats[0];
          if (b.is_cfg) begin
            if (expected_reads.size() == 0 && !busy && !start && settle >= SETTLE) begin
              void'(pending_beats.pop_front());
              nxt_we = 1'b1;
              cfg_addr <= b.cfg_reg;
              cfg_wdata <= b.cfg_val;
              if (b.cfg_reg == REG_STIFFNESS) stiff_m = b.cfg_val;
              else bnd_m = b.cfg_val;
            end
          end else begin
            void'(pending_beats.pop_front());
            cur = b;
            nxt_start = 1'b1;
            cmd <= b.op;
            node_index <= b.node;
            node_value <= b.val;
            node_boundary <= b.bnd;
            level <= b.lvl;
            hang_code <= b.fc;
            corner0_node <= b.corner[0];
            corner1_node <= b.corner[1];
            corner2_node <= b.corner[2];
            corner3_node <= b.corner[3];
            if ($urandom_range(0, 63) == 0) burst = !burst;
            if (burst) gap = 0;
            else if ($urandom_range(0, 11) == 0) gap = $urandom_range(10, 40);
            else if ($urandom_range(0, 1) == 0) gap = 0;
            else gap = $urandom_range(1, 3);
          end
        end
      end
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
  end

  // monitor
  always @(posedge clk) begin
    node_out_t e;
    if (!rst && strobe) begin
      if (expected_reads.size() == 0) begin
        report("unexpected result", 32'h0, {20'h0, result_index});
      end else begin
        e = expected_reads.pop_front();
        if (result_index !== e.idx) report("result_index", {20'h0, e.idx}, {20'h0, result_index});
        if (result_value !== e.val) report("result_value", e.val, result_value);
      end
    end
  end

  // watchdog: cycles with nothing moving
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic beat_t mk(cmd_t op);
    beat_t b;
    b.is_cfg = 1'b0;
    b.cfg_reg = REG_STIFFNESS;
    b.cfg_val = 1'b0;
    b.op = op;
    b.node = pool[$urandom_range(0, POOL_N - 1)];
    b.val = $urandom();
    b.bnd = ($urandom_range(0, 3) == 0);
    b.lvl = 4'($urandom_range(0, 15));
    b.fc = 4'($urandom_range(0, 15));
    for (int k = 0; k < 4; k++) b.corner[k] = pool[$urandom_range(0, POOL_N - 1)];
    return b;
  endfunction

  task automatic push_cfg(reg_idx_t r, logic v);
    beat_t b;
    b = mk(CMD_NONE);
    b.is_cfg = 1'b1;
    b.cfg_reg = r;
    b.cfg_val = v;
    pending_beats.push_back(b);
  endtask

  initial begin
    beat_t b;
    int sel;
    for (int i = 0; i < 4096; i++) begin
      x_store[i] = '0;
      flag_store[i] = 1'b0;
      y_store[i] = '0;
    end
    pool[0] = 12'd0;
    pool[1] = 12'hfff;
    for (int i = 2; i < POOL_N; i++) pool[i] = 12'($urandom());
    // every pool node is loaded before anything reads it
    for (int i = 0; i < POOL_N; i++) begin
      b = mk(CMD_LOAD);
      b.node = pool[i];
      if (i == 0) b.val = 32'h7fffffff;
      if (i == 1) b.val = 32'h80000000;
      if (i == 2) b.val = 32'h0;
      if (i < 4) b.bnd = 1'b0;
      pending_beats.push_back(b);
    end
    // directed: level extremes, every face code, ignored command, reads
    for (int f = 0; f < 16; f++) begin
      b = mk(CMD_ELEM);
      b.fc = 4'(f);
      b.lvl = (f % 2) ? 4'd15 : 4'd0;
      if (f == 0) b.corner = '{pool[0], pool[1], pool[0], pool[1]};
      pending_beats.push_back(b);
    end
    pending_beats.push_back(mk(CMD_NONE));
    for (int i = 0; i < 4; i++) begin
      b = mk(CMD_READ);
      b.node = pool[i];
      pending_beats.push_back(b);
    end
    // random phases over register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      push_cfg(REG_STIFFNESS, ph[0]);
      push_cfg(REG_BOUNDARY, ph[1] ^ ph[2]);
      for (int i = 0; i < 100; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 25) b = mk(CMD_LOAD);
        else if (sel < 65) b = mk(CMD_ELEM);
        else if (sel < 95) b = mk(CMD_READ);
        else begin
          b = mk(CMD_NONE);
          b.node = 12'($urandom());
          for (int k = 0; k < 4; k++) b.corner[k] = 12'($urandom());
        end
        if (b.op == CMD_ELEM && $urandom_range(0, 3) != 0) b.lvl = 4'($urandom_range(0, 2));
        pending_beats.push_back(b);
      end
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk);
    while (pending_beats.size() != 0 || start || expected_reads.size() != 0);
    repeat (SETTLE) @(posedge clk);
    if (errs == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/fema_pkg.sv
rtl/fema_ram.sv
rtl/fema_lane.sv
rtl/fe_element_matrix_apply.sv
rtl/fema_checker.sv
tb/testbench.sv
